### rtl/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants of the piezo hit detector.
// ----------------------------------------------------------------------------
package phd_pkg;

  localparam int CH_W     = 6;
  localparam int SAMPLE_W = 8;
  localparam int FRAMES_W = 9;
  localparam int SUM_W    = 16;
  localparam int AVG_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 9'd511;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_FRAMES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_FRAMES    = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_SCAN = 2'd1,
    PH_MASK = 2'd2
  } phase_t;

  // per-channel state word; all zero is the reset value
  typedef struct packed {
    logic [SAMPLE_W-1:0] prev;
    phase_t              phase;
    logic [FRAMES_W-1:0] frames;
    logic [SAMPLE_W-1:0] peak;
    logic [SUM_W-1:0]    sum;
  } entry_t;

endpackage

### rtl/phd_state_mem.sv
// ----------------------------------------------------------------------------
// phd_state_mem
// Per-channel state RAM, one read and one write port, registered read.
// Entries never written since reset read back as all zero.
// ----------------------------------------------------------------------------
module phd_state_mem import phd_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t           mem [DEPTH];
  entry_t           rd_q_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### rtl/phd_divider.sv
// ----------------------------------------------------------------------------
// phd_divider
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit
// per cycle. done pulses for one cycle; quotient holds until next start.
// ----------------------------------------------------------------------------
module phd_divider import phd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                done,
  output logic [SUM_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] dvs_r;
  logic [SUM_W-1:0]    q_r;

  logic [SAMPLE_W:0]   shifted;
  logic [SAMPLE_W:0]   diff;
  logic                ge;

  assign shifted = {rem_r, q_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/piezo_hit_detector.sv
// ----------------------------------------------------------------------------
// piezo_hit_detector
// Per-channel piezo trigger with scan and mask windows.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A sample for a channel outside
// PORTS*PINS_PER_PORT is dropped in its accept cycle. Other samples
// go through the state RAM read and then the evaluate/write-back. A sample
// that ends a scan also runs the serial divider for the average, one
// quotient bit per cycle; the hit beat is offered once the divider is
// done and the output register is free, and no new sample is taken before
// it is offered. A finished hit waits in the output register while the next
// samples are taken; only the following hit waits for it to drain. No
// clearing pass: state reads as zero until a channel is first written.
// ----------------------------------------------------------------------------
module piezo_hit_detector import phd_pkg::*; #(
  parameter int PORTS         = 8,
  parameter int PINS_PER_PORT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CH_W-1:0]      in_channel,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_hit_channel,
  output logic [SAMPLE_W-1:0]  out_peak,
  output logic [AVG_W-1:0]     out_average,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam int NUM_CH = PORTS * PINS_PER_PORT;
  localparam int DEPTH  = (NUM_CH > (1 << CH_W)) ? (1 << CH_W) : NUM_CH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] thr_r, scan_r, mask_r;
  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [SAMPLE_W-1:0] hit_peak_r;

  logic                out_valid_r;
  logic [CH_W-1:0]     out_ch_r;
  logic [SAMPLE_W-1:0] out_peak_r;
  logic [AVG_W-1:0]    out_avg_r;

  logic                in_range;
  logic                rd_en;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic                emit;
  logic [SAMPLE_W-1:0] scan_eff;
  logic                div_done;
  logic [SUM_W-1:0]    div_q;
  logic                out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_range  = int'(in_channel) < NUM_CH;
  assign rd_en     = in_valid && in_ready && in_range;
  assign scan_eff  = (scan_r == '0) ? SAMPLE_W'(1) : scan_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      scan_r <= SAMPLE_W'(1);
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RISE_THRESHOLD: thr_r  <= cfg_data;
        CFG_SCAN_FRAMES:    scan_r <= cfg_data;
        CFG_MASK_FRAMES:    mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  phd_state_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_channel[AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (state_r == ST_EVAL),
    .wr_addr (ch_r[AW-1:0]),
    .wr_data (wr_entry)
  );

  // evaluate one frame of the channel
  always_comb begin
    logic [FRAMES_W-1:0] f1;
    logic                trig;
    logic                mask_end;
    logic                scanning;
    f1       = rd_entry.frames;
    trig     = {1'b0, smp_r} >= ({1'b0, rd_entry.prev} + {1'b0, thr_r});
    wr_entry = rd_entry;
    emit     = 1'b0;
    if (rd_entry.phase != PH_WAIT && rd_entry.frames < FRAMES_MAX) begin
      f1 = rd_entry.frames + 1'b1;
    end
    mask_end = {1'b0, f1} >= ({2'b0, scan_eff} + {2'b0, mask_r});
    scanning = f1 < {1'b0, scan_eff};
    wr_entry.frames = f1;
    case (rd_entry.phase)
      PH_WAIT: begin
        if (trig) begin
          wr_entry.phase  = PH_SCAN;
          wr_entry.frames = '0;
          wr_entry.peak   = smp_r;
          wr_entry.sum    = {7'b0, smp_r, 1'b0};
        end
      end
      PH_SCAN: begin
        if (scanning) begin
          if (smp_r > rd_entry.peak) begin
            wr_entry.peak = smp_r;
          end
          wr_entry.sum = rd_entry.sum + {8'b0, smp_r};
        end else begin
          emit           = 1'b1;
          wr_entry.phase = mask_end ? PH_WAIT : PH_MASK;
          if (mask_end && trig) begin
            wr_entry.phase  = PH_SCAN;
            wr_entry.frames = '0;
            wr_entry.peak   = smp_r;
            wr_entry.sum    = {7'b0, smp_r, 1'b0};
          end
        end
      end
      PH_MASK: begin
        if (mask_end) begin
          wr_entry.phase = PH_WAIT;
          if (trig) begin
            wr_entry.phase  = PH_SCAN;
            wr_entry.frames = '0;
            wr_entry.peak   = smp_r;
            wr_entry.sum    = {7'b0, smp_r, 1'b0};
          end
        end
      end
      default: ;
    endcase
    wr_entry.prev = smp_r;
  end

  phd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == ST_EVAL) && emit),
    .dividend (rd_entry.sum),
    .divisor  (scan_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (rd_en) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = emit ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ch_r  <= in_channel;
      smp_r <= in_sample;
    end
    if (state_r == ST_EVAL) begin
      hit_peak_r <= rd_entry.peak;
    end
    if (state_r == ST_OUT && out_free) begin
      out_ch_r   <= ch_r;
      out_peak_r <= hit_peak_r;
      out_avg_r  <= div_q[AVG_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit_channel = out_ch_r;
  assign out_peak        = out_peak_r;
  assign out_average     = out_avg_r;

endmodule
